// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the expression evaluator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/iee_pkg.sv =====
`default_nettype none

package iee_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned STK_CW      = $clog2(STACK_DEPTH + 1);

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned HALF_W   = VALUE_W / 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OP_W     = 2;

  // operator codes held on the operator stack
  localparam logic [OP_W-1:0] OP_OPEN = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 2'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ERR_FORM  = 2'd1;
  localparam logic [STATUS_W-1:0] ERR_DEPTH = 2'd2;

  // character codes
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'd57;
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

  // partial product selects of the shared 32x32 multiplier
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  typedef struct packed {
    logic       take;
    logic       push_val;
    logic       push_op;
    logic       pop_open;
    logic       apply_start;
    logic       apply_wr;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       set_form_err;
    logic       load_out;
    logic       clear;
  } iee_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_open;
    logic is_close;
    logic last;
    logic err_set;
    logic op_empty;
    logic op_top_open;
    logic val_lt2;
    logic val_empty;
    logic op_is_mul;
  } iee_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/iee_dp.sv =====
`default_nettype none

`include "assert_macros.svh"

module iee_dp import iee_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SYM_W-1:0]    sym_i,
  input  wire logic                last_i,
  input  wire iee_cmd_t            cmd_i,
  output iee_stat_t                stat_o,
  output logic      [VALUE_W-1:0]  out_value_o,
  output logic      [STATUS_W-1:0] out_status_o
);

  logic [SYM_W-1:0]    sym_q;
  logic                last_q;
  logic [STK_CW-1:0]   opcnt_q, opcnt_d;
  logic [STK_CW-1:0]   valcnt_q, valcnt_d;
  logic [STATUS_W-1:0] err_q, err_d;
  logic [OP_W-1:0]     op_mem [STACK_DEPTH];
  logic [VALUE_W-1:0]  val_mem [STACK_DEPTH];
  logic [OP_W-1:0]     op_top_q;
  logic [VALUE_W-1:0]  top_q;
  logic [VALUE_W-1:0]  rd_q;
  logic [VALUE_W-1:0]  acc_q;
  logic [OP_W-1:0]     op_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [STATUS_W-1:0] out_status_q;

  logic [STK_CW-1:0]   op_dec, op_dec2, val_dec1, val_dec2;
  logic [OP_W-1:0]     sym_code;
  logic                op_full, val_full;
  logic [VALUE_W-1:0]  digit_val, addsub_res, apply_res;
  logic [HALF_W-1:0]   mul_x, mul_y;
  logic [VALUE_W-1:0]  prod;

  assign op_dec   = opcnt_q - STK_CW'(1);
  assign op_dec2  = opcnt_q - STK_CW'(2);
  assign val_dec1 = valcnt_q - STK_CW'(1);
  assign val_dec2 = valcnt_q - STK_CW'(2);
  assign op_full  = (opcnt_q == STK_CW'(STACK_DEPTH));
  assign val_full = (valcnt_q == STK_CW'(STACK_DEPTH));

  always_comb begin
    case (sym_q)
      CH_OPEN:  sym_code = OP_OPEN;
      CH_PLUS:  sym_code = OP_ADD;
      CH_MINUS: sym_code = OP_SUB;
      default:  sym_code = OP_MUL;
    endcase
  end

  assign digit_val = VALUE_W'(sym_q - CH_ZERO);

  always_comb begin
    stat_o             = '0;
    stat_o.is_digit    = sym_q inside {[CH_ZERO:CH_NINE]};
    stat_o.is_open     = (sym_q == CH_OPEN);
    stat_o.is_close    = (sym_q == CH_CLOSE);
    stat_o.last        = last_q;
    stat_o.err_set     = (err_q != ERR_NONE);
    stat_o.op_empty    = (opcnt_q == '0);
    stat_o.op_top_open = (op_top_q == OP_OPEN);
    stat_o.val_lt2     = (valcnt_q < STK_CW'(2));
    stat_o.val_empty   = (valcnt_q == '0);
    stat_o.op_is_mul   = (op_q == OP_MUL);
  end

  // a is the second entry (read from memory), b the cached top
  assign addsub_res = (op_q == OP_ADD) ? (rd_q + top_q) : (rd_q - top_q);
  assign apply_res  = (op_q == OP_MUL) ? acc_q : addsub_res;

  // one 32x32 product per cycle, low 64 bits built from three partials
  assign mul_x = (cmd_i.mul_sel == MUL_HL) ? rd_q[VALUE_W-1:HALF_W] : rd_q[HALF_W-1:0];
  assign mul_y = (cmd_i.mul_sel == MUL_LH) ? top_q[VALUE_W-1:HALF_W] : top_q[HALF_W-1:0];
  assign prod  = VALUE_W'(mul_x) * VALUE_W'(mul_y);

  always_comb begin
    err_d = err_q;
    if (cmd_i.clear) begin
      err_d = ERR_NONE;
    end else if (err_q == ERR_NONE) begin
      if ((cmd_i.push_val && val_full) || (cmd_i.push_op && op_full)) begin
        err_d = ERR_DEPTH;
      end else if ((cmd_i.apply_start && stat_o.val_lt2) || cmd_i.set_form_err) begin
        err_d = ERR_FORM;
      end
    end
  end

  always_comb begin
    opcnt_d = opcnt_q;
    if (cmd_i.clear) begin
      opcnt_d = '0;
    end else if (cmd_i.push_op && !op_full) begin
      opcnt_d = opcnt_q + STK_CW'(1);
    end else if (cmd_i.pop_open || cmd_i.apply_start) begin
      opcnt_d = op_dec;
    end
  end

  always_comb begin
    valcnt_d = valcnt_q;
    if (cmd_i.clear) begin
      valcnt_d = '0;
    end else if (cmd_i.push_val && !val_full) begin
      valcnt_d = valcnt_q + STK_CW'(1);
    end else if (cmd_i.apply_wr) begin
      valcnt_d = val_dec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcnt_q  <= '0;
      valcnt_q <= '0;
      err_q    <= ERR_NONE;
    end else begin
      opcnt_q  <= opcnt_d;
      valcnt_q <= valcnt_d;
      err_q    <= err_d;
    end
  end

  // value stack: top cached in top_q, deeper entries in memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_val && !val_full && (valcnt_q != '0)) begin
      val_mem[val_dec1[STK_AW-1:0]] <= top_q;
    end
    if (cmd_i.apply_start) begin
      rd_q <= val_mem[val_dec2[STK_AW-1:0]];
    end
  end

  // operator stack: top cached in op_top_q, deeper entries in memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_op && !op_full) begin
      if (opcnt_q != '0) begin
        op_mem[op_dec[STK_AW-1:0]] <= op_top_q;
      end
      op_top_q <= sym_code;
    end else if (cmd_i.pop_open || cmd_i.apply_start) begin
      op_top_q <= op_mem[op_dec2[STK_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sym_q  <= sym_i;
      last_q <= last_i;
    end
    if (cmd_i.apply_start) begin
      op_q <= op_top_q;
    end
    if (cmd_i.push_val && !val_full) begin
      top_q <= digit_val;
    end else if (cmd_i.apply_wr) begin
      top_q <= apply_res;
    end
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel == MUL_LL) begin
        acc_q <= prod;
      end else begin
        acc_q <= acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end
    if (cmd_i.load_out) begin
      out_value_q  <= (err_q == ERR_NONE) ? top_q : '0;
      out_status_q <= err_q;
    end
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  `ASSERT_NEVER(a_valcnt_range, clk_i, rst_ni, valcnt_q > STK_CW'(STACK_DEPTH))
  `ASSERT_NEVER(a_opcnt_range, clk_i, rst_ni, opcnt_q > STK_CW'(STACK_DEPTH))
  `ASSERT_CLK(a_err_sticky, clk_i, rst_ni, (err_q != ERR_NONE && !cmd_i.clear) |=> (err_q == $past(err_q)))

endmodule

`default_nettype wire

// ===== rtl/core/iee_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module iee_ctrl import iee_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  input  wire iee_stat_t stat_i,
  output iee_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_CLOSE  = 4'd2;
  localparam logic [3:0] S_PUSHOP = 4'd3;
  localparam logic [3:0] S_APPLY  = 4'd4;
  localparam logic [3:0] S_WAIT   = 4'd5;
  localparam logic [3:0] S_M0     = 4'd6;
  localparam logic [3:0] S_M1     = 4'd7;
  localparam logic [3:0] S_M2     = 4'd8;
  localparam logic [3:0] S_WR     = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_DRAIN  = 4'd11;
  localparam logic [3:0] S_ENDCHK = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic       out_valid_q, out_valid_d;
  logic [8:0] cmd_vec;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.err_set) begin
          state_d = S_FIN;
        end else if (stat_i.is_digit) begin
          cmd_o.push_val = 1'b1;
          state_d        = S_FIN;
        end else if (stat_i.is_open) begin
          cmd_o.push_op = 1'b1;
          state_d       = S_FIN;
        end else if (stat_i.is_close) begin
          state_d = S_CLOSE;
        end else if (!stat_i.op_empty && !stat_i.op_top_open) begin
          ret_d   = S_PUSHOP;
          state_d = S_APPLY;
        end else begin
          state_d = S_PUSHOP;
        end
      end
      S_CLOSE: begin
        if (stat_i.err_set) begin
          state_d = S_FIN;
        end else if (stat_i.op_empty) begin
          cmd_o.set_form_err = 1'b1;
          state_d            = S_FIN;
        end else if (stat_i.op_top_open) begin
          cmd_o.pop_open = 1'b1;
          state_d        = S_FIN;
        end else begin
          ret_d   = S_CLOSE;
          state_d = S_APPLY;
        end
      end
      S_PUSHOP: begin
        cmd_o.push_op = !stat_i.err_set;
        state_d       = S_FIN;
      end
      S_APPLY: begin
        cmd_o.apply_start = 1'b1;
        state_d           = stat_i.val_lt2 ? ret_q : S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.op_is_mul) begin
          state_d = S_M0;
        end else begin
          cmd_o.apply_wr = 1'b1;
          state_d        = ret_q;
        end
      end
      S_M0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LL;
        state_d       = S_M1;
      end
      S_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LH;
        state_d       = S_M2;
      end
      S_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HL;
        state_d       = S_WR;
      end
      S_WR: begin
        cmd_o.apply_wr = 1'b1;
        state_d        = ret_q;
      end
      S_FIN: begin
        state_d = stat_i.last ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (stat_i.err_set || stat_i.op_empty) begin
          state_d = S_ENDCHK;
        end else if (stat_i.op_top_open) begin
          cmd_o.set_form_err = 1'b1;
          state_d            = S_ENDCHK;
        end else begin
          ret_d   = S_DRAIN;
          state_d = S_APPLY;
        end
      end
      S_ENDCHK: begin
        cmd_o.set_form_err = !stat_i.err_set && stat_i.val_empty;
        state_d            = S_OUT;
      end
      S_OUT: begin
        // wait for the result register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_vec = {cmd_o.take, cmd_o.push_val, cmd_o.push_op, cmd_o.pop_open,
                    cmd_o.apply_start, cmd_o.apply_wr, cmd_o.mul_en,
                    cmd_o.set_form_err, cmd_o.load_out};

  `ASSERT_CLK(a_cmd_exclusive, clk_i, rst_ni, $onehot0(cmd_vec))
  `ASSERT_CLK(a_accept_leaves_idle, clk_i, rst_ni, (state_q == S_IDLE && in_valid_i) |=> (state_q == S_DISP))
  `ASSERT_CLK(a_load_sets_valid, clk_i, rst_ni, cmd_o.load_out |=> out_valid_q)

endmodule

`default_nettype wire

// ===== rtl/core/infix_expression_evaluator_top.sv =====
// infix expression evaluator, one character per input request
// input stream: tdata carries one character (digit, '(', ')', '+', '-', anything
// else multiplies), tlast marks the final character of an expression
// output stream: one result per expression, tdata the 64-bit wrapped value,
// tuser the status (0 ok, 1 malformed, 2 stack depth exceeded)
// all operators share one precedence and associate left to right
// characters are taken one at a time; a digit or '(' is taken, dispatched and
// finished, and an operator or ')' also passes a push or close step when
// nothing is applied
// an operator application reads its operands, then writes the result for add or
// subtract; a multiply runs as three partial products on one 32x32 multiplier
// before the write; after each application inside a ')' or the final drain the
// operator stack is checked again
// the result sits in a register, so the next expression can be taken while
// the receiver stalls; a new result waits only while the old one is unread
// reset empties both stacks, clears the status and drops any pending result;
// stacks are cleared again after every expression
`default_nettype none

module infix_expression_evaluator_top import iee_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] symbol
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [VALUE_W-1:0]  m_axis_tdata,   // [63:0] value
  output logic      [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

  iee_cmd_t  cmd;
  iee_stat_t stat;

  iee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  iee_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_i        (s_axis_tdata[SYM_W-1:0]),
    .last_i       (s_axis_tlast),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
